>>> rtl/lfuc_pkg.sv
`timescale 1ns / 1ps

package lfuc_pkg;

   // Default number of cells
   localparam int ENTRIES_DEFAULT = 64;

   // Field widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 16;
   localparam int CAP_W   = 7;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 2;

   // Use count saturates here
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Register byte addresses
   localparam logic [ADDR_W-1:0] CSR_CAPACITY = 2'd0;

   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Operation codes of the request
   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   // Commands broadcast from the controller to every cell
   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HIT  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FILL = 2'd3;

endpackage

>>> rtl/lfuc_cell.sv
`timescale 1ns / 1ps

module lfuc_cell #(
   parameter int  ENTRIES    = lfuc_pkg::ENTRIES_DEFAULT,
   parameter int  CELL_IDX   = 0,
   parameter type cmd_type   = logic,
   parameter type token_type = logic,
   parameter type stat_type  = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  token_type token_in,
   output token_type token_out,
   output stat_type  stat
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

   // Entry state
   logic                         valid_ff, valid_in;
   logic [lfuc_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lfuc_pkg::VALUE_W-1:0] val_ff, val_in;
   logic [lfuc_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic [IW-1:0]                rank_ff, rank_in;
   logic                         match_ff, match_in;
   token_type                    token_ff, token_in_nx;

   logic match;
   logic is_victim;
   logic is_slot;
   logic older_than_victim;
   logic better;

   assign match = valid_ff && (key_ff == cmd.key);

   assign stat.match = match;
   assign stat.rank  = rank_ff;
   assign stat.value = val_ff;

   // Entry update for the broadcast command
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      cnt_in   = cnt_ff;
      rank_in  = rank_ff;
      match_in = match_ff;
      is_victim = cmd.evict && (cmd.victim_idx == MY_IDX);
      is_slot   = cmd.slot_ok && (cmd.slot_idx == MY_IDX);
      older_than_victim = cmd.evict && (rank_ff > cmd.victim_rank);
      case (cmd.op)
         lfuc_pkg::CMD_LOOK: begin
            match_in = match;
         end
         lfuc_pkg::CMD_HIT: begin
            if (match_ff) begin
               if (cmd.set) begin
                  val_in = cmd.value;
               end
               if (cnt_ff != lfuc_pkg::COUNT_MAX) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               rank_in = '0;
            end else if (valid_ff && (rank_ff < cmd.ref_rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         lfuc_pkg::CMD_FILL: begin
            if (is_slot) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               val_in   = cmd.value;
               cnt_in   = lfuc_pkg::COUNT_W'(1);
               rank_in  = '0;
            end else if (is_victim) begin
               valid_in = 1'b0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1 - (older_than_victim ? IW'(1) : IW'(0));
            end
         end
         default: begin
         end
      endcase
   end

   // Victim and free-slot search: fold this entry into the passing token
   always_comb begin
      token_in_nx = token_in;
      better = !token_in.cand_ok || (cnt_ff < token_in.cand_cnt) ||
               ((cnt_ff == token_in.cand_cnt) && (rank_ff > token_in.cand_rank));
      if (valid_ff) begin
         if (better) begin
            token_in_nx.cand_ok   = 1'b1;
            token_in_nx.cand_cnt  = cnt_ff;
            token_in_nx.cand_rank = rank_ff;
            token_in_nx.cand_idx  = MY_IDX;
            token_in_nx.cand_key  = key_ff;
         end
      end else if (!token_in.free_ok) begin
         token_in_nx.free_ok  = 1'b1;
         token_in_nx.free_idx = MY_IDX;
      end
   end

   assign token_out = token_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         rank_ff  <= '0;
         token_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         rank_ff  <= rank_in;
         token_ff <= token_in_nx;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      val_ff <= val_in;
      cnt_ff <= cnt_in;
   end

endmodule

>>> rtl/lfuc_ctrl.sv
`timescale 1ns / 1ps

module lfuc_ctrl #(
   parameter int  ENTRIES    = lfuc_pkg::ENTRIES_DEFAULT,
   parameter type cmd_type   = logic,
   parameter type token_type = logic,
   parameter type stat_type  = logic
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic signed [lfuc_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lfuc_pkg::VALUE_W-1:0] req_write_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic signed [lfuc_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                              rsp_evicted,
   output logic signed [lfuc_pkg::KEY_W-1:0]   rsp_evicted_key,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lfuc_pkg::ADDR_W-1:0]       paddr,
   input  logic [lfuc_pkg::DATA_W-1:0]       pwdata,
   output logic [lfuc_pkg::DATA_W-1:0]       prdata,
   output logic                              pready,
   // cell row
   output cmd_type                           cmd,
   output token_type                         start_token,
   input  token_type                         end_token,
   input  stat_type                          stat [ENTRIES]
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UW = $clog2(ENTRIES + 1);
   localparam int CW = (UW > lfuc_pkg::CAP_W) ? UW : lfuc_pkg::CAP_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]                    state_ff, state_in;
   logic [lfuc_pkg::CAP_W-1:0]    cap_ff, cap_in;
   logic [UW-1:0]                 used_ff, used_in;
   logic [lfuc_pkg::CMD_W-1:0]    act_ff, act_in;

   // Transaction being worked on
   logic                          func_ff, func_in;
   logic [lfuc_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lfuc_pkg::VALUE_W-1:0]  wval_ff, wval_in;
   logic                          hit_ff, hit_in;
   logic [IW-1:0]                 hrank_ff, hrank_in;
   logic [lfuc_pkg::VALUE_W-1:0]  rdval_ff, rdval_in;
   logic                          evict_ff, evict_in;
   logic [IW-1:0]                 vidx_ff, vidx_in;
   logic [IW-1:0]                 vrank_ff, vrank_in;
   logic [lfuc_pkg::KEY_W-1:0]    vkey_ff, vkey_in;
   logic                          slot_ok_ff, slot_ok_in;
   logic [IW-1:0]                 slot_ff, slot_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [lfuc_pkg::VALUE_W-1:0]  rsp_rval_ff, rsp_rval_in;
   logic                          rsp_ev_ff, rsp_ev_in;
   logic [lfuc_pkg::KEY_W-1:0]    rsp_evkey_ff, rsp_evkey_in;

   logic                          out_free;
   logic                          finish;
   logic                          accept;
   logic                          csr_write;
   logic [CW-1:0]                 cap_eff;
   logic                          cap_zero;
   logic                          full;
   logic [ENTRIES-1:0]            match_vec;
   logic                          hit_any;
   logic [IW-1:0]                 hit_rank;
   logic [lfuc_pkg::VALUE_W-1:0]  hit_val;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr == lfuc_pkg::CSR_CAPACITY) ?
                      lfuc_pkg::DATA_W'(cap_ff) : '0;
   assign cap_in    = (csr_write && (paddr == lfuc_pkg::CSR_CAPACITY)) ?
                      pwdata[lfuc_pkg::CAP_W-1:0] : cap_ff;

   // Capacity clamped to the cell count
   assign cap_eff  = (CW'(cap_ff) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_ff);
   assign cap_zero = (cap_eff == '0);
   assign full     = (CW'(used_ff) >= cap_eff);

   // Match reduction across the row (keys are unique, so OR is enough)
   always_comb begin
      hit_any  = 1'b0;
      hit_rank = '0;
      hit_val  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = stat[i].match;
         hit_any  = hit_any | stat[i].match;
         hit_rank = hit_rank | ({IW{stat[i].match}} & stat[i].rank);
         hit_val  = hit_val | ({lfuc_pkg::VALUE_W{stat[i].match}} & stat[i].value);
      end
   end

   // Handshakes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_RESP) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || finish);
   assign accept    = req_valid && !req_stall;

   // Search token enters the first cell on a set miss
   always_comb begin
      start_token = '0;
      start_token.live = (state_ff == ST_LOOK) && !cap_zero && !hit_any &&
                         (func_ff == lfuc_pkg::FUNC_SET);
   end

   // Broadcast command
   always_comb begin
      cmd = '0;
      cmd.set         = (func_ff == lfuc_pkg::FUNC_SET);
      cmd.key         = key_ff;
      cmd.value       = wval_ff;
      cmd.ref_rank    = hrank_ff;
      cmd.victim_idx  = vidx_ff;
      cmd.victim_rank = vrank_ff;
      cmd.slot_idx    = slot_ff;
      cmd.op          = lfuc_pkg::CMD_NONE;
      if (state_ff == ST_LOOK) begin
         cmd.op = lfuc_pkg::CMD_LOOK;
      end else if (finish) begin
         cmd.op = act_ff;
      end
      cmd.evict   = (cmd.op == lfuc_pkg::CMD_FILL) && evict_ff;
      cmd.slot_ok = (cmd.op == lfuc_pkg::CMD_FILL) && slot_ok_ff;
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      func_in    = func_ff;
      key_in     = key_ff;
      wval_in    = wval_ff;
      hit_in     = hit_ff;
      hrank_in   = hrank_ff;
      rdval_in   = rdval_ff;
      evict_in   = evict_ff;
      vidx_in    = vidx_ff;
      vrank_in   = vrank_ff;
      vkey_in    = vkey_ff;
      slot_ok_in = slot_ok_ff;
      slot_in    = slot_ff;
      used_in    = used_ff;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOK: begin
            hit_in   = hit_any && !cap_zero;
            hrank_in = hit_rank;
            rdval_in = (hit_any && !cap_zero && (func_ff == lfuc_pkg::FUNC_GET)) ?
                       hit_val : '0;
            evict_in = 1'b0;
            vkey_in  = '0;
            if (cap_zero) begin
               act_in   = lfuc_pkg::CMD_NONE;
               state_in = ST_RESP;
            end else if (hit_any) begin
               act_in   = lfuc_pkg::CMD_HIT;
               state_in = ST_RESP;
            end else if (func_ff == lfuc_pkg::FUNC_GET) begin
               act_in   = lfuc_pkg::CMD_NONE;
               state_in = ST_RESP;
            end else begin
               act_in   = lfuc_pkg::CMD_FILL;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (end_token.live) begin
               evict_in = full && end_token.cand_ok;
               vidx_in  = end_token.cand_idx;
               vrank_in = end_token.cand_rank;
               vkey_in  = (full && end_token.cand_ok) ? end_token.cand_key : '0;
               if (full && end_token.cand_ok) begin
                  slot_ok_in = 1'b1;
                  slot_in    = (end_token.free_ok && (end_token.free_idx < end_token.cand_idx)) ?
                               end_token.free_idx : end_token.cand_idx;
               end else begin
                  slot_ok_in = end_token.free_ok;
                  slot_in    = end_token.free_idx;
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (finish) begin
               state_in = ST_IDLE;
               if (act_ff == lfuc_pkg::CMD_FILL) begin
                  used_in = used_ff - (evict_ff ? UW'(1) : UW'(0)) +
                            (slot_ok_ff ? UW'(1) : UW'(0));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept) begin
         func_in  = req_func;
         key_in   = req_key;
         wval_in  = req_write_value;
         state_in = ST_LOOK;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_rval_in  = rsp_rval_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evkey_in = rsp_evkey_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_rval_in  = rdval_ff;
         rsp_ev_in    = (act_ff == lfuc_pkg::CMD_FILL) && evict_ff;
         rsp_evkey_in = (act_ff == lfuc_pkg::CMD_FILL) ? vkey_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_rval_ff;
   assign rsp_evicted     = rsp_ev_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= lfuc_pkg::CAP_RESET;
         used_ff      <= '0;
         act_ff       <= lfuc_pkg::CMD_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      wval_ff      <= wval_in;
      hit_ff       <= hit_in;
      hrank_ff     <= hrank_in;
      rdval_ff     <= rdval_in;
      evict_ff     <= evict_in;
      vidx_ff      <= vidx_in;
      vrank_ff     <= vrank_in;
      vkey_ff      <= vkey_in;
      slot_ok_ff   <= slot_ok_in;
      slot_ff      <= slot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_rval_ff  <= rsp_rval_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_evkey_ff <= rsp_evkey_in;
   end

   // Checks
   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> $onehot0(match_vec))
      else $error("more than one cell matches the key");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_ff))
      else $error("response reports both hit and eviction");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      UW'(ENTRIES) >= used_ff)
      else $error("occupancy above cell count");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      end_token.live |-> (state_ff == ST_SCAN))
      else $error("search token left the row outside a scan");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_rval_ff == '0))
      else $error("read value on a miss");

endmodule

>>> rtl/lfu_cache_lru_tiebreak.sv
`timescale 1ns / 1ps

// Key-value cache, least-frequently-used replacement, oldest entry loses a tie.
// Request channel (req_*): func (get/set), key, write_value; a transaction is
// taken when req_valid is high and req_stall low. Response channel (rsp_*):
// one response per request, in order: hit, read_value, evicted, evicted_key.
// Register port: capacity_in_use at byte address 0 (0 disables the cache).
// Each entry lives in a cell of a row of ENTRIES cells; all cells compare the
// key in parallel in the LOOK state, and the update is broadcast to them when
// the result enters the response register. A get, or a set that hits, passes
// from acceptance through LOOK and RESP; the next request can be taken as its
// result enters the response register. A set that misses also sends a search
// token down the cell row, one cell per cycle, to find the victim and the lowest free cell.
// Reset empties the cache and sets the capacity to 64; no clearing pass.
// The response register holds a result while rsp_stall is high; the next
// request can be accepted meanwhile, and its result waits for the register.

module lfu_cache_lru_tiebreak #(
   parameter int ENTRIES = lfuc_pkg::ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic signed [lfuc_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lfuc_pkg::VALUE_W-1:0] req_write_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic signed [lfuc_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                                rsp_evicted,
   output logic signed [lfuc_pkg::KEY_W-1:0]   rsp_evicted_key,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lfuc_pkg::ADDR_W-1:0]         paddr,
   input  logic [lfuc_pkg::DATA_W-1:0]         pwdata,
   output logic [lfuc_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Command broadcast to all cells
   typedef struct packed {
      logic [lfuc_pkg::CMD_W-1:0]   op;
      logic                         set;
      logic [lfuc_pkg::KEY_W-1:0]   key;
      logic [lfuc_pkg::VALUE_W-1:0] value;
      logic [IW-1:0]                ref_rank;
      logic                         evict;
      logic [IW-1:0]                victim_idx;
      logic [IW-1:0]                victim_rank;
      logic                         slot_ok;
      logic [IW-1:0]                slot_idx;
   } cmd_type;

   // Search token passed from cell to cell
   typedef struct packed {
      logic                         live;
      logic                         cand_ok;
      logic [lfuc_pkg::COUNT_W-1:0] cand_cnt;
      logic [IW-1:0]                cand_rank;
      logic [IW-1:0]                cand_idx;
      logic [lfuc_pkg::KEY_W-1:0]   cand_key;
      logic                         free_ok;
      logic [IW-1:0]                free_idx;
   } token_type;

   // Per-cell lookup status
   typedef struct packed {
      logic                         match;
      logic [IW-1:0]                rank;
      logic [lfuc_pkg::VALUE_W-1:0] value;
   } stat_type;

   cmd_type   cmd;
   token_type token [ENTRIES+1];
   stat_type  stat [ENTRIES];

   // Cell row, token chained left to right
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfuc_cell #(
         .ENTRIES    (ENTRIES),
         .CELL_IDX   (g),
         .cmd_type   (cmd_type),
         .token_type (token_type),
         .stat_type  (stat_type)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .token_in  (token[g]),
         .token_out (token[g+1]),
         .stat      (stat[g])
      );
   end

   lfuc_ctrl #(
      .ENTRIES    (ENTRIES),
      .cmd_type   (cmd_type),
      .token_type (token_type),
      .stat_type  (stat_type)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .cmd             (cmd),
      .start_token     (token[0]),
      .end_token       (token[ENTRIES]),
      .stat            (stat)
   );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int ENTRIES       = lfuc_pkg::ENTRIES_DEFAULT;
   localparam int DIRECTED_ROWS = 27;
   localparam int KEY_POOL      = 68;
   localparam int SEGMENTS      = 9;
   localparam int SEG_ITEMS     = 42;
   localparam int LONG_HOLD     = 300;

   // One response of the cache
   typedef struct packed {
      logic                                hit;
      logic signed [lfuc_pkg::VALUE_W-1:0] read_value;
      logic                                evicted;
      logic signed [lfuc_pkg::KEY_W-1:0]   evicted_key;
   } lookup_result_type;

   // Response written into a stimulus row, or left to the predictor
   typedef struct packed {
      bit                known;
      lookup_result_type result;
   } typed_lookup_type;

   typedef enum logic [1:0] {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic                         func;
      logic [lfuc_pkg::KEY_W-1:0]   key;
      logic [lfuc_pkg::VALUE_W-1:0] wval;   // capacity for ROW_CAPACITY rows
      bit                           known;
      lookup_result_type            result;
   } stim_row_type;

   localparam lookup_result_type NO_RESULT = '0;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_func = lfuc_pkg::FUNC_GET;
   logic signed [lfuc_pkg::KEY_W-1:0]   req_key = '0;
   logic signed [lfuc_pkg::VALUE_W-1:0] req_write_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_hit;
   logic signed [lfuc_pkg::VALUE_W-1:0] rsp_read_value;
   logic                                rsp_evicted;
   logic signed [lfuc_pkg::KEY_W-1:0]   rsp_evicted_key;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [lfuc_pkg::ADDR_W-1:0]         paddr = '0;
   logic [lfuc_pkg::DATA_W-1:0]         pwdata = '0;
   logic [lfuc_pkg::DATA_W-1:0]         prdata;
   logic                                pready;

   lfu_cache_lru_tiebreak #(.ENTRIES(ENTRIES)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_key(req_key), .req_write_value(req_write_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value), .rsp_evicted(rsp_evicted),
      .rsp_evicted_key(rsp_evicted_key),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the cache contents
   bit                           slot_valid [ENTRIES];
   logic [lfuc_pkg::KEY_W-1:0]   slot_key   [ENTRIES];
   logic [lfuc_pkg::VALUE_W-1:0] slot_value [ENTRIES];
   logic [lfuc_pkg::COUNT_W-1:0] slot_count [ENTRIES];
   int                           slot_age   [ENTRIES];   // 0 = most recently used
   int                           slots_filled = 0;
   logic [lfuc_pkg::CAP_W-1:0]   model_capacity = lfuc_pkg::CAP_RESET;

   lookup_result_type          expected_lookups [$];
   typed_lookup_type           typed_lookups [$];
   stim_row_type               directed_rows [DIRECTED_ROWS];
   logic [lfuc_pkg::KEY_W-1:0] key_pool [KEY_POOL];

   int  items_sent = 0;
   int  results_seen = 0;
   int  hits_seen = 0;
   int  evictions_seen = 0;
   int  capacity_writes = 0;
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_go = 1'b0;
   bit  holding = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Next response of the cache for one transaction; updates the shadow copy
   function automatic lookup_result_type predict_lookup(
         input logic func,
         input logic [lfuc_pkg::KEY_W-1:0] key,
         input logic [lfuc_pkg::VALUE_W-1:0] wval);
      lookup_result_type res;
      int limit;
      int slot;
      int victim;
      int free_slot;
      int old_age;
      res = NO_RESULT;
      limit = (model_capacity > ENTRIES) ? ENTRIES : int'(model_capacity);
      if (limit == 0)
         return res;

      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (slot < 0 && slot_valid[i] && slot_key[i] == key)
            slot = i;

      // hit: bump the count (saturating) and move to the front
      if (slot >= 0) begin
         res.hit = 1'b1;
         if (func == lfuc_pkg::FUNC_GET)
            res.read_value = slot_value[slot];
         else
            slot_value[slot] = wval;
         if (slot_count[slot] != lfuc_pkg::COUNT_MAX)
            slot_count[slot]++;
         old_age = slot_age[slot];
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && i != slot && slot_age[i] < old_age)
               slot_age[i]++;
         slot_age[slot] = 0;
         return res;
      end
      if (func == lfuc_pkg::FUNC_GET)
         return res;

      // full: drop lowest count, oldest among equals
      if (slots_filled >= limit) begin
         victim = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i])
               continue;
            if (victim < 0 || slot_count[i] < slot_count[victim] ||
                (slot_count[i] == slot_count[victim] && slot_age[i] > slot_age[victim]))
               victim = i;
         end
         if (victim >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = slot_key[victim];
            slot_valid[victim] = 1'b0;
            old_age = slot_age[victim];
            for (int i = 0; i < ENTRIES; i++)
               if (slot_valid[i] && slot_age[i] > old_age)
                  slot_age[i]--;
            if (slots_filled > 0)
               slots_filled--;
         end
      end

      // fill the lowest free slot as most recent
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (free_slot < 0 && !slot_valid[i])
            free_slot = i;
      if (free_slot >= 0) begin
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i])
               slot_age[i]++;
         slot_valid[free_slot] = 1'b1;
         slot_key[free_slot] = key;
         slot_value[free_slot] = wval;
         slot_count[free_slot] = lfuc_pkg::COUNT_W'(1);
         slot_age[free_slot] = 0;
         slots_filled++;
      end
      return res;
   endfunction

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= 10)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   // Offer one transaction and hold it until accepted
   task automatic offer(input logic func, input logic [lfuc_pkg::KEY_W-1:0] key,
                        input logic [lfuc_pkg::VALUE_W-1:0] wval, input bit known,
                        input lookup_result_type typed);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      typed_lookups.push_back('{known, typed});
      req_valid <= 1'b1;
      req_func <= func;
      req_key <= key;
      req_write_value <= wval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
   endtask

   // Optional write of the capacity register, then read back
   task automatic access_capacity(input bit do_write,
                                  input logic [lfuc_pkg::DATA_W-1:0] data);
      if (do_write) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= lfuc_pkg::CSR_CAPACITY;
         pwdata <= data;
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         while (!pready) @(posedge clock);
         model_capacity = data[lfuc_pkg::CAP_W-1:0];
         capacity_writes++;
      end
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= lfuc_pkg::CSR_CAPACITY;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== lfuc_pkg::DATA_W'(model_capacity))
         flag_error($sformatf("capacity readback: expected %0d, got %h",
                              model_capacity, prdata));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Predict on every accepted request
   always @(posedge clock) begin : accept_monitor
      lookup_result_type predicted;
      typed_lookup_type typed;
      if (!reset && req_valid && !req_stall) begin
         predicted = predict_lookup(req_func, req_key, req_write_value);
         typed = typed_lookups.pop_front();
         expected_lookups.push_back(typed.known ? typed.result : predicted);
      end
   end

   // Compare every accepted response with the oldest expectation
   always @(posedge clock) begin : response_check
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_hit === 1'b1)
            hits_seen++;
         if (rsp_evicted === 1'b1)
            evictions_seen++;
         if (expected_lookups.size() == 0) begin
            flag_error("response with no transaction outstanding");
         end else begin
            want = expected_lookups.pop_front();
            if (rsp_hit !== want.hit || rsp_read_value !== want.read_value ||
                rsp_evicted !== want.evicted || rsp_evicted_key !== want.evicted_key)
               flag_error($sformatf({"response %0d: expected hit=%0d value=%h ",
                  "evicted=%0d key=%h, got hit=%0d value=%h evicted=%0d key=%h"},
                  results_seen, want.hit, want.read_value, want.evicted,
                  want.evicted_key, rsp_hit, rsp_read_value, rsp_evicted,
                  rsp_evicted_key));
         end
      end
   end

   // Response side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= holding || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Long receiver hold-off so the pipeline backs up into the request side
   initial begin : long_hold
      wait (hold_go);
      holding <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      holding <= 1'b0;
   end

   initial begin
      #10000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      stim_row_type row;
      logic [lfuc_pkg::KEY_W-1:0] key;
      logic [lfuc_pkg::VALUE_W-1:0] wval;
      int caps [SEGMENTS];
      int span;
      int idx;

      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_age[i] = 0;
      end
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < KEY_POOL; i++)
         key_pool[i] = $urandom;

      // extremes, hits and misses, LFU then LRU eviction, disabled and oversize capacity
      directed_rows = '{
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h0000_0000, 32'h0, 1'b1, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h8000_0000, 32'h0, 1'b1,
           '{1'b1, 32'sh7FFF_FFFF, 1'b0, 32'sh0}},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0, 1'b1,
           '{1'b1, 32'shFFFF_FFFF, 1'b0, 32'sh0}},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'h7FFF_FFFF, 32'h0, 1'b1,
           '{1'b1, 32'sh0, 1'b0, 32'sh0}},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, NO_RESULT},
         '{ROW_CAPACITY, lfuc_pkg::FUNC_GET, 32'h0, 32'd2, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'd5, 32'd55, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'd6, 32'd66, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'd6, 32'h0, 1'b0, NO_RESULT},
         '{ROW_CAPACITY, lfuc_pkg::FUNC_GET, 32'h0, 32'd3, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'd7, 32'd77, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'd7, 32'h0, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'd8, 32'd88, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'd6, 32'h0, 1'b0, NO_RESULT},
         '{ROW_CAPACITY, lfuc_pkg::FUNC_GET, 32'h0, 32'd0, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'd10, 32'd1, 1'b1, NO_RESULT},
         '{ROW_CAPACITY, lfuc_pkg::FUNC_GET, 32'h0, 32'd127, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'h0, 32'hAAAA_AAAA, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h0, 32'h0, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'h8000_0000, 32'h5555_5555, 1'b0, NO_RESULT},
         '{ROW_CAPACITY, lfuc_pkg::FUNC_GET, 32'h0, 32'd1, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_SET, 32'h1234_5678, 32'd1, 1'b0, NO_RESULT},
         '{ROW_ITEM, lfuc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, NO_RESULT}
      };
      caps = '{64, 5, 1, 127, 0, 24, 2, 64, 9};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      access_capacity(1'b0, '0);

      // directed table, no idling
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         if (row.kind == ROW_CAPACITY) begin
            drain();
            access_capacity(1'b1, row.wval);
         end else begin
            offer(row.func, row.key, row.wval, row.known, row.result);
         end
      end

      // random segments, one capacity setting each
      idx = 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         access_capacity(1'b1, ($urandom & ~32'h7F) | lfuc_pkg::DATA_W'(caps[seg]));
         span = ((caps[seg] > ENTRIES) ? ENTRIES : caps[seg]) + 3;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            if (idx < SEGMENTS * SEG_ITEMS / 3) begin
               send_idle_pct = 35;
               recv_idle_pct = 60;
            end else if (idx < 2 * SEGMENTS * SEG_ITEMS / 3) begin
               send_idle_pct = 60;
               recv_idle_pct = 35;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            if (idx == 20)
               hold_go = 1'b1;
            if ($urandom_range(99) < 80)
               key = key_pool[$urandom_range(span - 1)];
            else
               key = $urandom;
            wval = ($urandom_range(9) == 0) ? '1 : $urandom;
            offer(1'($urandom_range(1)), key, wval, 1'b0, NO_RESULT);
            idx++;
         end
      end

      drain();
      repeat (ENTRIES + 8) @(posedge clock);
      if (expected_lookups.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_lookups.size()));

      $display("Covered %0d transactions, %0d responses (%0d hits, %0d evictions),",
               items_sent, results_seen, hits_seen, evictions_seen);
      $display("%0d capacity writes incl. disabled, oversize and shrink; %0d errors",
               capacity_writes, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lfuc_pkg.sv
rtl/lfuc_cell.sv
rtl/lfuc_ctrl.sv
rtl/lfu_cache_lru_tiebreak.sv
verif/testbench.sv
